// File: design/bvm_pkg.sv
// Package: shared types, opcodes and constants for the bytecode step core
`default_nettype none
package bvm_pkg;
  localparam int NumRegsDef   = 16;
  localparam int DstackDef    = 256;
  localparam int RstackDef    = 64;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_END = 3'd1, ST_ILLEGAL = 3'd2, ST_EXIT = 3'd3, ST_STACK = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_LOAD = 5'd1, OP_LOAD8 = 5'd2, OP_LOAD16 = 5'd3, OP_LOAD32 = 5'd4,
    OP_LDS = 5'd5, OP_STS = 5'd6, OP_PUSH = 5'd7, OP_POP = 5'd8, OP_ADD = 5'd9,
    OP_SUB = 5'd10, OP_MUL = 5'd11, OP_DIV = 5'd12, OP_AND = 5'd13, OP_OR = 5'd14,
    OP_XOR = 5'd15, OP_NOT = 5'd16, OP_SHL = 5'd17, OP_SHR = 5'd18, OP_CMP = 5'd19,
    OP_LT = 5'd20, OP_LTE = 5'd21, OP_JP = 5'd22, OP_JPC = 5'd23, OP_CALL = 5'd24,
    OP_CALLC = 5'd25, OP_RET = 5'd26, OP_EXCALL = 5'd27, OP_INV = 5'd28, OP_EXIT = 5'd29,
    OP_BAD30 = 5'd30, OP_BAD31 = 5'd31
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_DIV, S_OUT
  } state_t;

  // divider request/response
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

// File: design/bvm_ram.sv
// Generic single-port synchronous RAM with registered read
`default_nettype none
module bvm_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: design/bvm_div.sv
// Restoring divider, one quotient bit per cycle
`default_nettype none
module bvm_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bvm_pkg::div_req_t req,
  output bvm_pkg::div_rsp_t      rsp
);
  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] den;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        quo  <= req.num;
        rem  <= '0;
        den  <= req.den;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // zero divisor: restoring division already gives all ones
  assign rsp = {done, quo};

  assert property (@(posedge clk) disable iff (rst) req.start |=> busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) rsp.done |-> $past(busy))
    else $error("divider done while idle");
  assert property (@(posedge clk) disable iff (rst) busy |-> cnt != 6'd0)
    else $error("divider count ran out while busy");
endmodule
`default_nettype wire

// File: design/bytecode_vm_step_core.sv
// Top level: bytecode step core with stack memories and sequencer
//
//  channel | dir | handshake        | words
//  in      | in  | in_valid/in_stall | opcode, operand_one..operand_five
//  out     | out | out_valid/out_stall | status, next_pc, exit_value, compare_flag
//  cfg     | in  | cfg_we           | cfg_data (program_size)
//
// An instruction passes through the states accept, stack memory read, execute and result.
// DIV waits in S_DIV for the shift-subtract divider between execute and result.
// The result register holds while out_stall is high; no new word is taken until it is taken.
// Reset clears pc, registers, flag and stack counts; stack memories are not cleared.
`default_nettype none
module bytecode_vm_step_core #(
  parameter int NumRegs = bvm_pkg::NumRegsDef,
  parameter int DstackDepth = bvm_pkg::DstackDef,
  parameter int RstackDepth = bvm_pkg::RstackDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  opcode,
  input  wire logic [7:0]  operand_one,
  input  wire logic [7:0]  operand_two,
  input  wire logic [7:0]  operand_three,
  input  wire logic [7:0]  operand_four,
  input  wire logic [7:0]  operand_five,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [31:0]      next_pc,
  output logic [31:0]      exit_value,
  output logic             compare_flag,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data
);
  localparam int DW = $clog2(DstackDepth);
  localparam int RW = $clog2(RstackDepth);
  localparam int DC = $clog2(DstackDepth + 1);
  localparam int RC = $clog2(RstackDepth + 1);
  localparam int RI = (NumRegs > 1) ? $clog2(NumRegs) : 1;

  bvm_pkg::state_t state, state_next;

  logic [31:0] program_size, pc;
  logic        cflag;
  logic [31:0] regs [NumRegs];
  logic [DC-1:0] dcount;
  logic [RC-1:0] rcount;

  // latched instruction word
  logic [7:0] op8, b1, b2, b3, b4, b5;

  // memories
  logic          d_we, r_we;
  logic [DW-1:0] d_addr;
  logic [RW-1:0] r_addr;
  logic [31:0]   d_wdata, r_wdata, d_rdata, r_rdata;

  bvm_ram #(.Width(32), .Depth(DstackDepth)) u_dstack (
    .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata));
  bvm_ram #(.Width(32), .Depth(RstackDepth)) u_rstack (
    .clk(clk), .we(r_we), .addr(r_addr), .wdata(r_wdata), .rdata(r_rdata));

  bvm_pkg::div_req_t dreq;
  bvm_pkg::div_rsp_t drsp;
  bvm_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // decode
  bvm_pkg::op_t op;
  logic [3:0]  hi, lo;
  logic [32:0] pc33;
  logic        fit0, fit1, fit2, fit3, fit4, fit5;
  logic        hi_ok, lo_ok, b1_ok;
  logic [31:0] ra, rb, rb1, imm32, jmp;
  logic        big_op;

  assign big_op = op8 > 8'd31;
  assign op = bvm_pkg::op_t'(op8[4:0]);
  assign hi = b1[7:4];
  assign lo = b1[3:0];
  assign pc33 = {1'b0, pc};
  assign fit0 = pc33 + 33'd0 < {1'b0, program_size};
  assign fit1 = pc33 + 33'd1 < {1'b0, program_size};
  assign fit2 = pc33 + 33'd2 < {1'b0, program_size};
  assign fit3 = pc33 + 33'd3 < {1'b0, program_size};
  assign fit4 = pc33 + 33'd4 < {1'b0, program_size};
  assign fit5 = pc33 + 33'd5 < {1'b0, program_size};
  assign hi_ok = {4'd0, hi} < 8'(NumRegs);
  assign lo_ok = {4'd0, lo} < 8'(NumRegs);
  assign b1_ok = {1'b0, b1} < 9'(NumRegs);
  assign ra  = hi_ok ? regs[hi[RI-1:0]] : '0;
  assign rb  = lo_ok ? regs[lo[RI-1:0]] : '0;
  assign rb1 = b1_ok ? regs[b1[RI-1:0]] : '0;
  assign imm32 = {b5, b4, b3, b2};
  assign jmp   = {b4, b3, b2, b1};

  // stack offset checks, offset 0 is the top
  logic          off_ok;
  logic [DC-1:0] off_idx;
  assign off_ok  = {{(DC > 8 ? DC-8 : 0){1'b0}}, b2} < dcount;
  assign off_idx = dcount - DC'(1) - DC'(b2);

  // result
  logic [2:0]  res_status;
  logic [31:0] res_pc, res_code;
  logic        res_flag;
  logic        in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = state != bvm_pkg::S_IDLE;

  // execute-stage outcome
  logic [2:0]  ex_status;
  logic [31:0] ex_pc, ex_code, ex_val;
  logic        ex_wr, ex_flag, ex_div;
  logic [3:0]  ex_dst;
  logic [DC-1:0] dcount_ex;
  logic [RC-1:0] rcount_ex;
  logic [31:0] alu_a, alu_b;
  logic        taken, is_call;

  always_comb begin
    ex_status = bvm_pkg::ST_OK;
    ex_pc = pc;
    ex_code = '0;
    ex_val = '0;
    ex_wr = 1'b0;
    ex_dst = b1[3:0];
    ex_flag = cflag;
    ex_div = 1'b0;
    dcount_ex = dcount;
    rcount_ex = rcount;
    alu_a = ra;
    alu_b = rb;
    taken = 1'b0;
    is_call = 1'b0;
    if (!fit0) begin
      ex_status = bvm_pkg::ST_END;
    end else if (big_op) begin
      ex_status = bvm_pkg::ST_ILLEGAL;
    end else begin
      unique case (op)
        bvm_pkg::OP_NOP: ex_pc = pc + 32'd1;
        bvm_pkg::OP_LOAD, bvm_pkg::OP_ADD, bvm_pkg::OP_SUB, bvm_pkg::OP_MUL,
        bvm_pkg::OP_DIV, bvm_pkg::OP_AND, bvm_pkg::OP_OR, bvm_pkg::OP_XOR,
        bvm_pkg::OP_SHL, bvm_pkg::OP_SHR, bvm_pkg::OP_CMP, bvm_pkg::OP_LT,
        bvm_pkg::OP_LTE: begin
          if (!fit1 || !hi_ok || !lo_ok) begin
            ex_status = bvm_pkg::ST_ILLEGAL;
          end else begin
            ex_pc = pc + 32'd2;
            ex_dst = hi;
            ex_wr = 1'b1;
            case (op)
              bvm_pkg::OP_LOAD: ex_val = rb;
              bvm_pkg::OP_ADD:  ex_val = ra + rb;
              bvm_pkg::OP_SUB:  ex_val = ra - rb;
              bvm_pkg::OP_MUL:  ex_val = ra * rb;
              bvm_pkg::OP_DIV:  ex_div = 1'b1;
              bvm_pkg::OP_AND:  ex_val = ra & rb;
              bvm_pkg::OP_OR:   ex_val = ra | rb;
              bvm_pkg::OP_XOR:  ex_val = ra ^ rb;
              bvm_pkg::OP_SHL:  ex_val = (rb >= 32'd32) ? '0 : ra << rb[4:0];
              bvm_pkg::OP_SHR:  ex_val = (rb >= 32'd32) ? '0 : ra >> rb[4:0];
              bvm_pkg::OP_CMP: begin ex_wr = 1'b0; ex_flag = ra == rb; end
              bvm_pkg::OP_LT:  begin ex_wr = 1'b0; ex_flag = ra < rb; end
              default:         begin ex_wr = 1'b0; ex_flag = ra <= rb; end
            endcase
          end
        end
        bvm_pkg::OP_NOT: begin
          if (!fit1 || !lo_ok) ex_status = bvm_pkg::ST_ILLEGAL;
          else begin
            ex_pc = pc + 32'd2; ex_dst = lo; ex_wr = 1'b1; ex_val = ~rb;
          end
        end
        bvm_pkg::OP_LOAD8, bvm_pkg::OP_LOAD16, bvm_pkg::OP_LOAD32, bvm_pkg::OP_LDS,
        bvm_pkg::OP_STS, bvm_pkg::OP_PUSH, bvm_pkg::OP_POP: begin
          if (!b1_ok || !((op == bvm_pkg::OP_LOAD16) ? fit3 :
                          (op == bvm_pkg::OP_LOAD32) ? fit5 :
                          (op == bvm_pkg::OP_PUSH || op == bvm_pkg::OP_POP) ? fit1 : fit2))
            ex_status = bvm_pkg::ST_ILLEGAL;
          else begin
            case (op)
              bvm_pkg::OP_LOAD8: begin
                ex_wr = 1'b1; ex_val = {24'd0, b2}; ex_pc = pc + 32'd3;
              end
              bvm_pkg::OP_LOAD16: begin
                ex_wr = 1'b1; ex_val = {16'd0, b3, b2}; ex_pc = pc + 32'd4;
              end
              bvm_pkg::OP_LOAD32: begin
                ex_wr = 1'b1; ex_val = imm32; ex_pc = pc + 32'd6;
              end
              bvm_pkg::OP_LDS: begin
                ex_wr = 1'b1; ex_val = off_ok ? d_rdata : '0; ex_pc = pc + 32'd3;
              end
              bvm_pkg::OP_STS: ex_pc = pc + 32'd3;
              bvm_pkg::OP_PUSH: begin
                if (dcount >= DC'(DstackDepth)) ex_status = bvm_pkg::ST_STACK;
                else begin dcount_ex = dcount + DC'(1); ex_pc = pc + 32'd2; end
              end
              default: begin
                if (dcount == '0) ex_status = bvm_pkg::ST_STACK;
                else begin
                  dcount_ex = dcount - DC'(1); ex_wr = 1'b1; ex_val = d_rdata;
                  ex_pc = pc + 32'd2;
                end
              end
            endcase
          end
        end
        bvm_pkg::OP_JP, bvm_pkg::OP_JPC, bvm_pkg::OP_CALL, bvm_pkg::OP_CALLC: begin
          taken = op == bvm_pkg::OP_JP || op == bvm_pkg::OP_CALL || cflag;
          is_call = op == bvm_pkg::OP_CALL || op == bvm_pkg::OP_CALLC;
          if (!fit4) ex_status = bvm_pkg::ST_ILLEGAL;
          else if (!taken) ex_pc = pc + 32'd5;
          else if (is_call && rcount >= RC'(RstackDepth)) ex_status = bvm_pkg::ST_STACK;
          else begin
            ex_pc = jmp;
            if (is_call) rcount_ex = rcount + RC'(1);
          end
        end
        bvm_pkg::OP_RET: begin
          if (rcount == '0) ex_status = bvm_pkg::ST_STACK;
          else begin rcount_ex = rcount - RC'(1); ex_pc = r_rdata; end
        end
        bvm_pkg::OP_INV: begin ex_flag = !cflag; ex_pc = pc + 32'd1; end
        bvm_pkg::OP_EXIT: begin
          if (!fit1 || !b1_ok) ex_status = bvm_pkg::ST_ILLEGAL;
          else begin ex_status = bvm_pkg::ST_EXIT; ex_code = rb1; end
        end
        default: ex_status = bvm_pkg::ST_ILLEGAL;
      endcase
    end
    if (ex_status != bvm_pkg::ST_OK) begin
      ex_wr = 1'b0; ex_div = 1'b0; ex_flag = cflag; ex_pc = pc;
      dcount_ex = dcount; rcount_ex = rcount;
    end
  end

  // memory addressing from latched word (valid in S_READ)
  logic is_lds_sts, is_push, is_pop, is_call_c;
  always_comb begin
    is_lds_sts = !big_op && (op == bvm_pkg::OP_LDS || op == bvm_pkg::OP_STS);
    is_push = !big_op && op == bvm_pkg::OP_PUSH;
    is_pop  = !big_op && op == bvm_pkg::OP_POP;
    is_call_c = !big_op && (op == bvm_pkg::OP_CALL || op == bvm_pkg::OP_CALLC);
    d_addr = is_lds_sts ? off_idx[DW-1:0] :
             is_push ? dcount[DW-1:0] : DW'(dcount - DC'(1));
    r_addr = is_call_c ? rcount[RW-1:0] : RW'(rcount - RC'(1));
    d_we = 1'b0;
    r_we = 1'b0;
    d_wdata = rb1;
    r_wdata = pc + 32'd5;
    if (state == bvm_pkg::S_EXEC && ex_status == bvm_pkg::ST_OK) begin
      d_we = is_push || (is_lds_sts && op == bvm_pkg::OP_STS && off_ok);
      r_we = is_call_c && rcount_ex != rcount;
    end
  end

  assign dreq.start = state == bvm_pkg::S_EXEC && ex_div;
  assign dreq.num = ra;
  assign dreq.den = rb;

  always_ff @(posedge clk) begin
    if (rst) state <= bvm_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bvm_pkg::S_IDLE: if (in_acc) state_next = bvm_pkg::S_READ;
      bvm_pkg::S_READ: state_next = bvm_pkg::S_EXEC;
      bvm_pkg::S_EXEC: state_next = ex_div ? bvm_pkg::S_DIV : bvm_pkg::S_OUT;
      bvm_pkg::S_DIV:  if (drsp.done) state_next = bvm_pkg::S_OUT;
      bvm_pkg::S_OUT:  if (out_acc) state_next = bvm_pkg::S_IDLE;
      default:         state_next = bvm_pkg::S_IDLE;
    endcase
  end

  logic [3:0] div_dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_size <= '0;
      pc <= '0;
      cflag <= 1'b0;
      dcount <= '0;
      rcount <= '0;
      for (int i = 0; i < NumRegs; i++) regs[i] <= '0;
    end else begin
      if (cfg_we) program_size <= cfg_data;
      if (in_acc) begin
        op8 <= opcode; b1 <= operand_one; b2 <= operand_two;
        b3 <= operand_three; b4 <= operand_four; b5 <= operand_five;
      end
      if (state == bvm_pkg::S_EXEC) begin
        pc <= ex_pc;
        cflag <= ex_flag;
        dcount <= dcount_ex;
        rcount <= rcount_ex;
        div_dst <= ex_dst;
        if (ex_wr && !ex_div) regs[ex_dst[RI-1:0]] <= ex_val;
        res_status <= ex_status;
        res_code <= ex_code;
      end
      if (state == bvm_pkg::S_DIV && drsp.done)
        regs[div_dst[RI-1:0]] <= drsp.quo;
    end
  end

  assign res_pc = pc;
  assign res_flag = cflag;
  assign out_valid = state == bvm_pkg::S_OUT;
  assign status = res_status;
  assign next_pc = res_pc;
  assign exit_value = res_code;
  assign compare_flag = res_flag;

  assert property (@(posedge clk) disable iff (rst) in_acc |=> state == bvm_pkg::S_READ)
    else $error("accepted word not read");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_pc))
    else $error("result lost under stall");
  assert property (@(posedge clk) disable iff (rst) dcount <= DC'(DstackDepth))
    else $error("data stack count overflow");
  assert property (@(posedge clk) disable iff (rst) rcount <= RC'(RstackDepth))
    else $error("return stack count overflow");
endmodule
`default_nettype wire
